// ===== hdl/flash_sector_writeback_buffer_assert.svh =====
// Assertion macros shared by the sector buffer RTL.
`ifndef FLASH_SECTOR_WRITEBACK_BUFFER_ASSERT_SVH
`define FLASH_SECTOR_WRITEBACK_BUFFER_ASSERT_SVH

// Checked only outside reset.
`define FSWB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FSWB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fswb_pkg.sv =====
`timescale 1ns / 1ps

package fswb_pkg;

  // Section geometry
  localparam int SECTORS_PER_SECTION = 8;
  localparam int SECTION_W = 13;
  localparam int SLOT_W = 3;
  localparam int MASK_W = 8;
  localparam logic [MASK_W-1:0] SLOT_MASK = MASK_W'((1 << SECTORS_PER_SECTION) - 1);

  // Result buffer sizing
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W = 2;

  localparam logic [15:0] INTERVAL_RESET = 16'd10000;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CYCLE = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    KIND_REJECT        = 4'd0,
    KIND_READ_START    = 4'd1,
    KIND_READ_SECTION  = 4'd2,
    KIND_READ_FLASH    = 4'd3,
    KIND_WRITE_START   = 4'd4,
    KIND_WRITE_SECTION = 4'd5,
    KIND_COMMIT_START  = 4'd6,
    KIND_COMMIT_SECTION = 4'd7,
    KIND_CYCLE_END     = 4'd8
  } kind_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] lba;
    logic        whole_sector;
    logic        forced;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    kind_t                kind;
    logic [SECTION_W-1:0] section;
    logic [SLOT_W-1:0]    sector;
    logic [MASK_W-1:0]    fill_mask;
    logic                 cycle_ran;
    logic                 last;
  } result_t;

endpackage

// ===== hdl/fswb_policy.sv =====
`timescale 1ns / 1ps

// Cache policy: holds buffer state, decides the results of one request.
module fswb_policy (
  input  logic                   clk,
  input  logic                   rst,
  input  fswb_pkg::item_t        item,
  input  logic                   take,
  input  logic [15:0]            commit_period,
  output fswb_pkg::result_t      results [fswb_pkg::MAX_RESULTS],
  output logic [fswb_pkg::CNT_W-1:0] result_count
);
  import fswb_pkg::*;

  logic                 start_dirty, start_dirty_next;
  logic [SECTION_W-1:0] open_section, open_section_next;
  logic [MASK_W-1:0]    dirty_mask, dirty_mask_next;
  logic [31:0]          last_commit_ms, last_commit_ms_next;

  logic [SECTION_W-1:0] sec;
  logic [SLOT_W-1:0]    slot;
  logic [MASK_W-1:0]    slot_bit;
  logic [31:0]          due_ms;
  logic [CNT_W-1:0]     n;

  // Address split and interval deadline
  assign sec      = SECTION_W'(item.lba / SECTORS_PER_SECTION);
  assign slot     = SLOT_W'(item.lba % SECTORS_PER_SECTION);
  assign slot_bit = MASK_W'(1) << slot;
  assign due_ms   = last_commit_ms + 32'(commit_period);

  // Result and next-state decision
  always_comb begin
    n = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      results[i] = '0;
    end
    start_dirty_next    = start_dirty;
    open_section_next   = open_section;
    dirty_mask_next     = dirty_mask;
    last_commit_ms_next = last_commit_ms;

    unique case (item.action)
      ACT_READ: begin
        results[0].last   = 1'b1;
        n = CNT_W'(1);
        if (!item.whole_sector) begin
          results[0].kind = KIND_REJECT;
        end else begin
          results[0].section = sec;
          results[0].sector  = slot;
          if (sec == '0) begin
            results[0].kind = KIND_READ_START;
          end else if (sec == open_section && (dirty_mask & slot_bit) != '0) begin
            results[0].kind = KIND_READ_SECTION;
          end else begin
            results[0].kind = KIND_READ_FLASH;
          end
        end
      end
      ACT_WRITE: begin
        if (!item.whole_sector) begin
          results[0].kind = KIND_REJECT;
          results[0].last = 1'b1;
          n = CNT_W'(1);
        end else if (sec == '0) begin
          start_dirty_next   = 1'b1;
          results[0].kind    = KIND_WRITE_START;
          results[0].sector  = slot;
          results[0].last    = 1'b1;
          n = CNT_W'(1);
        end else begin
          // Switching sections flushes the old one first
          if (sec != open_section && dirty_mask != '0) begin
            results[n].kind      = KIND_COMMIT_SECTION;
            results[n].section   = open_section;
            results[n].fill_mask = ~dirty_mask & SLOT_MASK;
            n = n + CNT_W'(1);
            dirty_mask_next = slot_bit & SLOT_MASK;
          end else begin
            dirty_mask_next = (dirty_mask | slot_bit) & SLOT_MASK;
          end
          open_section_next  = sec;
          results[n].kind    = KIND_WRITE_SECTION;
          results[n].section = sec;
          results[n].sector  = slot;
          results[n].last    = 1'b1;
          n = n + CNT_W'(1);
        end
      end
      ACT_CYCLE: begin
        if (!item.forced && item.now_ms < due_ms) begin
          results[0].kind = KIND_CYCLE_END;
          results[0].last = 1'b1;
          n = CNT_W'(1);
        end else begin
          last_commit_ms_next = item.now_ms;
          if (start_dirty) begin
            results[n].kind = KIND_COMMIT_START;
            n = n + CNT_W'(1);
            start_dirty_next = 1'b0;
          end
          if (dirty_mask != '0) begin
            results[n].kind      = KIND_COMMIT_SECTION;
            results[n].section   = open_section;
            results[n].fill_mask = ~dirty_mask & SLOT_MASK;
            n = n + CNT_W'(1);
            dirty_mask_next = '0;
          end
          results[n].kind      = KIND_CYCLE_END;
          results[n].cycle_ran = 1'b1;
          results[n].last      = 1'b1;
          n = n + CNT_W'(1);
        end
      end
      default: begin
        results[0].kind = KIND_REJECT;
        results[0].last = 1'b1;
        n = CNT_W'(1);
      end
    endcase
  end

  assign result_count = n;

  // Buffer state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_dirty    <= 1'b0;
      open_section   <= '0;
      dirty_mask     <= '0;
      last_commit_ms <= '0;
    end else if (take) begin
      start_dirty    <= start_dirty_next;
      open_section   <= open_section_next;
      dirty_mask     <= dirty_mask_next;
      last_commit_ms <= last_commit_ms_next;
    end
  end

endmodule

// ===== hdl/flash_sector_writeback_buffer.sv =====
`timescale 1ns / 1ps

// Write-back sector cache policy for a flash-backed disk. A request is
// registered on transfer, decided by the policy logic once the result buffer
// is free, and its one to three results are then delivered one per cycle,
// while rsp_stall is low, from a small result buffer. The next request may be
// transferred while results are still waiting, and it is decided in the cycle
// the last waiting result leaves. The interval register is written through
// cfg_valid/cfg_data, which is always ready, and should only change while idle.
module flash_sector_writeback_buffer (
  input  logic        clk,
  input  logic        rst,
  // Interval register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  action,
  input  logic [15:0] lba,
  input  logic        whole_sector,
  input  logic        forced,
  input  logic [31:0] now_ms,
  // Result channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [3:0]  kind,
  output logic [12:0] section,
  output logic [2:0]  sector,
  output logic [7:0]  fill_mask,
  output logic        cycle_ran,
  output logic        last
);
  import fswb_pkg::*;

  logic [15:0]      commit_period;
  item_t            item;
  logic             item_valid;
  logic             take;
  logic             buf_free;
  logic             req_xfer;
  logic             rsp_xfer;
  result_t          results [MAX_RESULTS];
  logic [CNT_W-1:0] result_count;
  result_t          res_buf [MAX_RESULTS];
  logic [CNT_W-1:0] head;
  logic [CNT_W-1:0] count;
  result_t          head_res;

  // Interval register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      commit_period <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      commit_period <= cfg_data;
    end
  end

  // Handshake control
  assign rsp_valid = (count != '0);
  assign rsp_xfer  = rsp_valid && !rsp_stall;
  assign buf_free  = (count == '0) || (count == CNT_W'(1) && rsp_xfer);
  assign take      = item_valid && buf_free;
  assign req_stall = item_valid && !take;
  assign req_xfer  = req_valid && !req_stall;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_xfer) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      item.action       <= action;
      item.lba          <= lba;
      item.whole_sector <= whole_sector;
      item.forced       <= forced;
      item.now_ms       <= now_ms;
    end
  end

  fswb_policy u_policy (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .take          (take),
    .commit_period (commit_period),
    .results       (results),
    .result_count  (result_count)
  );

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (take) begin
      head  <= '0;
      count <= result_count;
    end else if (rsp_xfer) begin
      head  <= head + CNT_W'(1);
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_buf[i] <= results[i];
      end
    end
  end

  // Result fields
  assign head_res  = res_buf[head];
  assign kind      = head_res.kind;
  assign section   = head_res.section;
  assign sector    = head_res.sector;
  assign fill_mask = head_res.fill_mask;
  assign cycle_ran = head_res.cycle_ran;
  assign last      = head_res.last;

`include "flash_sector_writeback_buffer_assert.svh"

  `FSWB_ASSERT(a_last_closes, rsp_valid |-> (last == (count == CNT_W'(1))), "bad last flag")
  `FSWB_ASSERT(a_take_fills, take |=> rsp_valid, "decided request left no result")
  `FSWB_ASSERT_ALWAYS(a_stall_needs_item, req_stall |-> item_valid, "stall with no item")

endmodule
